>>> hdl/indexed_deque_store_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the indexed deque store.
// Concurrent checks clocked on i_clk, with and without a reset guard.
// ----------------------------------------------------------------------------
`ifndef INDEXED_DEQUE_STORE_ASSERT_SVH
`define INDEXED_DEQUE_STORE_ASSERT_SVH

// Check that is switched off while reset is held.
`define IDS_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check that is also evaluated during reset.
`define IDS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hdl/ids_pkg.sv
// ----------------------------------------------------------------------------
// ids_pkg
// Types, codes and sizes shared by the indexed deque store.
// ----------------------------------------------------------------------------
package ids_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam logic [3:0] FUNC_PUSH_FRONT = 4'd0;
    localparam logic [3:0] FUNC_PUSH_BACK  = 4'd1;
    localparam logic [3:0] FUNC_POP_FRONT  = 4'd2;
    localparam logic [3:0] FUNC_POP_BACK   = 4'd3;
    localparam logic [3:0] FUNC_INSERT     = 4'd4;
    localparam logic [3:0] FUNC_DELETE     = 4'd5;
    localparam logic [3:0] FUNC_READ       = 4'd6;
    localparam logic [3:0] FUNC_WRITE      = 4'd7;
    localparam logic [3:0] FUNC_CLEAR      = 4'd8;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic [3:0]         func;
        logic [4:0]         position;
        logic signed [31:0] data_in;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] data_out;
        logic [1:0]         status;
        logic [4:0]         occupancy;
    } t_out_word;

endpackage

>>> hdl/indexed_deque_store.sv
// ----------------------------------------------------------------------------
// indexed_deque_store
// Ordered store of up to CAPACITY signed 32-bit values with push and pop at
// both ends, insert, delete, read and write at a position, and clear.
//
// Each input word (i_in_valid/o_in_ready) carries one operation; each
// operation returns exactly one output word (o_out_valid/i_out_ready) with a
// status, the occupancy after the operation and the value read or removed.
// An accepted word is held in an input register and executed against the
// slot registers once the output register is free or being read; the next
// slot values are all formed in parallel and the result lands in an output
// register. One word is taken per cycle while the receiver does not stall.
// If the receiver stalls, the output word holds and the input register
// holds its word; o_in_ready drops once both are occupied. Reset empties
// the store at once (no clearing pass); slot contents are not reset.
// ----------------------------------------------------------------------------
module indexed_deque_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ids_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ids_pkg::t_out_word  o_out_word
);
    import ids_pkg::*;

    logic                    r_in_valid;
    t_in_word                r_in_word;
    logic                    r_out_valid;
    t_out_word               r_out_word;
    logic [CNT_W-1:0]        r_fill;
    logic signed [31:0]      r_slots [CAPACITY];

    logic                    n_in_valid;
    logic                    n_out_valid;
    t_out_word               n_out_word;
    logic [CNT_W-1:0]        n_fill;
    logic signed [31:0]      n_slots [CAPACITY];

    logic                    w_process;
    logic                    w_full;
    logic [CNT_W-1:0]        w_pos;
    logic [CNT_W-1:0]        w_at;
    logic                    w_ins_en;
    logic                    w_del_en;
    logic                    w_wr_en;
    logic signed [31:0]      w_rd_data;

    assign w_process  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_process;
    assign n_in_valid = i_in_valid || (r_in_valid && !w_process);
    assign n_out_valid = w_process || (r_out_valid && !i_out_ready);

    assign w_full = (r_fill >= CNT_W'(CAPACITY));
    assign w_pos  = CNT_W'(r_in_word.position);

    // Position that the operation works on, taken from the function code.
    always_comb begin
        case (r_in_word.func)
            FUNC_PUSH_BACK: w_at = r_fill;
            FUNC_POP_BACK:  w_at = r_fill - CNT_W'(1);
            FUNC_PUSH_FRONT,
            FUNC_POP_FRONT: w_at = '0;
            default:        w_at = w_pos;
        endcase
    end

    assign w_rd_data = r_slots[w_at[IDX_W-1:0]];

    always_comb begin
        n_out_word           = '0;
        n_out_word.status    = STATUS_OK;
        n_fill               = r_fill;
        w_ins_en             = 1'b0;
        w_del_en             = 1'b0;
        w_wr_en              = 1'b0;
        unique case (r_in_word.func)
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK, FUNC_INSERT: begin
                if (w_full) begin
                    n_out_word.status = STATUS_FULL;
                end else if (w_at > r_fill) begin
                    n_out_word.status = STATUS_RANGE;
                end else begin
                    w_ins_en = 1'b1;
                    n_fill   = r_fill + CNT_W'(1);
                end
            end
            FUNC_POP_FRONT, FUNC_POP_BACK, FUNC_DELETE: begin
                if (r_fill == '0 || w_at >= r_fill) begin
                    n_out_word.status = STATUS_RANGE;
                end else begin
                    w_del_en            = 1'b1;
                    n_out_word.data_out = w_rd_data;
                    n_fill              = r_fill - CNT_W'(1);
                end
            end
            FUNC_READ: begin
                if (w_pos >= r_fill) begin
                    n_out_word.status = STATUS_RANGE;
                end else begin
                    n_out_word.data_out = w_rd_data;
                end
            end
            FUNC_WRITE: begin
                if (w_pos >= r_fill) begin
                    n_out_word.status = STATUS_RANGE;
                end else begin
                    w_wr_en = 1'b1;
                end
            end
            FUNC_CLEAR: begin
                n_fill = '0;
            end
            default: begin
            end
        endcase
        n_out_word.occupancy = 5'(n_fill);
    end

    // Every slot picks its next value from itself or a neighbor, so an insert
    // or delete moves the whole tail by one place at once. Slots at
    // or above the fill count may take stale values; they are never read.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_slots[i] = r_slots[i];
        end
        for (int i = 1; i < CAPACITY; i++) begin
            if (w_ins_en && CNT_W'(i) > w_at) begin
                n_slots[i] = r_slots[i-1];
            end
        end
        for (int i = 0; i < CAPACITY - 1; i++) begin
            if (w_del_en && CNT_W'(i) >= w_at) begin
                n_slots[i] = r_slots[i+1];
            end
        end
        for (int i = 0; i < CAPACITY; i++) begin
            if ((w_ins_en || w_wr_en) && CNT_W'(i) == w_at) begin
                n_slots[i] = r_in_word.data_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fill      <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (w_process) begin
                r_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_word <= i_in_word;
        end
        if (w_process) begin
            r_out_word <= n_out_word;
            r_slots    <= n_slots;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`include "indexed_deque_store_assert.svh"

    `IDS_ASSERT_RUN(a_occ_bound,
        o_out_valid |-> (o_out_word.occupancy <= 5'(CAPACITY)),
        "occupancy above capacity")
    `IDS_ASSERT_ALWAYS(a_fill_idle,
        (i_rst_n && !w_process) |=> (!i_rst_n || $stable(r_fill)),
        "fill count changed without an operation")
    `IDS_ASSERT_ALWAYS(a_refused_keeps_fill,
        (i_rst_n && w_process && n_out_word.status != STATUS_OK)
            |=> (!i_rst_n || $stable(r_fill)),
        "refused operation changed the fill count")
    `IDS_ASSERT_RUN(a_no_overrun,
        (r_in_valid && r_out_valid && !i_out_ready) |-> !o_in_ready,
        "input taken while both registers are held")

endmodule

>>> tb/sv/indexed_deque_store_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_deque_store_checker
// Watches both channels of the indexed deque store. It keeps a shadow copy of
// the stored sequence, works out the result of every accepted operation,
// queues it, and compares each returned word field by field in order.
// ----------------------------------------------------------------------------
module indexed_deque_store_checker
    import ids_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_pending
);

    logic [31:0] shadow_slots [CAPACITY];
    int          shadow_fill = 0;
    t_out_word   replies_due [$];
    int          fault_count = 0;
    int          due_count   = 0;

    assign o_fail_count = fault_count;
    assign o_pending    = due_count;

    task automatic report_fault(input string msg);
        $display("[%0t] ERROR %s", $time, msg);
        fault_count++;
    endtask

    // Applies one operation to the shadow sequence and returns its result word.
    function automatic t_out_word model_deque_op(input t_in_word w);
        t_out_word r;
        int        at;
        int        i;
        r        = '0;
        r.status = STATUS_OK;
        case (w.func)
            FUNC_PUSH_FRONT, FUNC_PUSH_BACK, FUNC_INSERT: begin
                if (w.func == FUNC_PUSH_FRONT) at = 0;
                else if (w.func == FUNC_PUSH_BACK) at = shadow_fill;
                else at = int'(w.position);
                // A full store refuses before the position is looked at.
                if (shadow_fill == CAPACITY) begin
                    r.status = STATUS_FULL;
                end else if (at > shadow_fill) begin
                    r.status = STATUS_RANGE;
                end else begin
                    for (i = shadow_fill; i > at; i--) shadow_slots[i] = shadow_slots[i - 1];
                    shadow_slots[at] = w.data_in;
                    shadow_fill++;
                end
            end
            FUNC_POP_FRONT, FUNC_POP_BACK, FUNC_DELETE: begin
                if (w.func == FUNC_POP_FRONT) at = 0;
                else if (w.func == FUNC_POP_BACK) at = shadow_fill - 1;
                else at = int'(w.position);
                if (shadow_fill == 0 || at >= shadow_fill) begin
                    r.status = STATUS_RANGE;
                end else begin
                    r.data_out = shadow_slots[at];
                    for (i = at; i + 1 < shadow_fill; i++) shadow_slots[i] = shadow_slots[i + 1];
                    shadow_fill--;
                end
            end
            FUNC_READ: begin
                if (int'(w.position) >= shadow_fill) r.status = STATUS_RANGE;
                else r.data_out = shadow_slots[w.position];
            end
            FUNC_WRITE: begin
                if (int'(w.position) >= shadow_fill) r.status = STATUS_RANGE;
                else shadow_slots[w.position] = w.data_in;
            end
            FUNC_CLEAR: begin
                shadow_fill = 0;
            end
            default: begin
            end
        endcase
        r.occupancy = 5'(shadow_fill);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            shadow_fill = 0;
            replies_due.delete();
        end else begin
            if (i_in_valid && i_in_ready) replies_due.push_back(model_deque_op(i_in_word));
            if (i_out_valid && i_out_ready) begin
                if (replies_due.size() == 0) begin
                    report_fault($sformatf("result word %h with nothing expected", i_out_word));
                end else begin
                    want = replies_due.pop_front();
                    if (i_out_word.data_out !== want.data_out)
                        report_fault($sformatf("data_out %h, expected %h",
                                               i_out_word.data_out, want.data_out));
                    if (i_out_word.status !== want.status)
                        report_fault($sformatf("status %0d, expected %0d",
                                               i_out_word.status, want.status));
                    if (i_out_word.occupancy !== want.occupancy)
                        report_fault($sformatf("occupancy %0d, expected %0d",
                                               i_out_word.occupancy, want.occupancy));
                end
            end
        end
        due_count = replies_due.size();
    end

endmodule

>>> tb/sv/indexed_deque_store_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_deque_store_tb
// Drives the indexed deque store with a short directed sequence covering the
// empty and out-of-range cases, then phases of random operations that
// lean toward growing, mixing or shrinking the store, with random gaps on
// both channels. A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module indexed_deque_store_tb;
    import ids_pkg::*;

    localparam logic [3:0] FUNC_UNUSED_LO = 4'd9;
    localparam logic [3:0] FUNC_UNUSED_HI = 4'd15;
    localparam int         WATCHDOG_LIMIT = 200;
    localparam int         PHASES         = 19;
    localparam int         PHASE_LEN      = 100;

    typedef enum int {MIX_GROW, MIX_MIXED, MIX_SHRINK} t_mix;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;
    logic      calm      = 1'b0;
    int        fail_count;
    int        pending;
    int        idle_cycles = 0;

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    indexed_deque_store dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    indexed_deque_store_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic t_in_word make_word(input logic [3:0] f, input logic [4:0] p,
                                           input logic [31:0] d);
        t_in_word w;
        w.func     = f;
        w.position = p;
        w.data_in  = d;
        return w;
    endfunction

    function automatic t_in_word random_op(input t_mix mix);
        t_in_word w;
        int       r;
        int       roll;
        int       grow_pct;
        int       shrink_pct;
        grow_pct   = (mix == MIX_GROW) ? 65 : (mix == MIX_MIXED) ? 35 : 15;
        shrink_pct = (mix == MIX_GROW) ? 15 : (mix == MIX_MIXED) ? 30 : 60;
        r = $urandom_range(0, 99);
        if (r < grow_pct) begin
            roll = $urandom_range(0, 2);
            w.func = (roll == 0) ? FUNC_PUSH_FRONT : (roll == 1) ? FUNC_PUSH_BACK : FUNC_INSERT;
        end else if (r < grow_pct + shrink_pct) begin
            roll = $urandom_range(0, 2);
            w.func = (roll == 0) ? FUNC_POP_FRONT : (roll == 1) ? FUNC_POP_BACK : FUNC_DELETE;
        end else if (r < 96) begin
            w.func = ($urandom_range(0, 1) == 0) ? FUNC_READ : FUNC_WRITE;
        end else if (r < 98) begin
            w.func = (mix == MIX_MIXED) ? FUNC_CLEAR : FUNC_READ;
        end else begin
            w.func = 4'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
        end
        // Mostly positions that can be valid, some near the front, a few wild.
        roll = $urandom_range(0, 9);
        if (roll == 0) w.position = 5'($urandom_range(0, 31));
        else if (roll <= 3) w.position = 5'($urandom_range(0, 3));
        else w.position = 5'($urandom_range(0, CAPACITY));
        roll = $urandom_range(0, 15);
        case (roll)
            0:       w.data_in = 32'h8000_0000;
            1:       w.data_in = 32'h7fff_ffff;
            2:       w.data_in = '1;
            3:       w.data_in = '0;
            default: w.data_in = $urandom;
        endcase
        return w;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_op(input t_in_word w);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!(in_valid && in_ready));
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    initial begin
        int stall;
        wait (rst_n);
        @(negedge clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            @(negedge clk);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("FAIL indexed_deque_store");
            $finish;
        end
    end

    initial begin
        int phase;
        int k;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Refusals on an empty store.
        send_op(make_word(FUNC_POP_FRONT, 5'd0, 32'h0));
        send_op(make_word(FUNC_POP_BACK, 5'd0, 32'h0));
        send_op(make_word(FUNC_DELETE, 5'd0, 32'h0));
        send_op(make_word(FUNC_READ, 5'd0, 32'h0));
        send_op(make_word(FUNC_WRITE, 5'd0, 32'h5));
        send_op(make_word(FUNC_INSERT, 5'd1, 32'h1));
        // Build a short sequence with the value extremes.
        send_op(make_word(FUNC_INSERT, 5'd0, 32'h7fff_ffff));
        send_op(make_word(FUNC_PUSH_BACK, 5'd0, 32'h8000_0000));
        send_op(make_word(FUNC_PUSH_FRONT, 5'd31, 32'hffff_ffff));
        send_op(make_word(FUNC_INSERT, 5'd3, 32'h1234_5678));
        send_op(make_word(FUNC_INSERT, 5'd5, 32'h0));
        send_op(make_word(FUNC_READ, 5'd3, 32'h0));
        send_op(make_word(FUNC_READ, 5'd4, 32'h0));
        send_op(make_word(FUNC_READ, 5'd31, 32'hffff_ffff));
        send_op(make_word(FUNC_WRITE, 5'd1, 32'h0));
        send_op(make_word(FUNC_READ, 5'd1, 32'h0));
        send_op(make_word(FUNC_DELETE, 5'd1, 32'h0));
        send_op(make_word(FUNC_DELETE, 5'd3, 32'h0));
        send_op(make_word(FUNC_POP_BACK, 5'd0, 32'h0));
        send_op(make_word(FUNC_POP_FRONT, 5'd0, 32'h0));
        send_op(make_word(FUNC_UNUSED_LO, 5'd31, 32'hffff_ffff));
        send_op(make_word(FUNC_UNUSED_HI, 5'd16, 32'h0));
        // Clear keeps slot contents, but a read past the new count is refused.
        send_op(make_word(FUNC_CLEAR, 5'd0, 32'h0));
        send_op(make_word(FUNC_READ, 5'd0, 32'h0));
        send_op(make_word(FUNC_PUSH_BACK, 5'd0, 32'h5555_aaaa));
        hold_until_drained();

        for (phase = 0; phase < PHASES; phase++) begin
            calm = (phase % 5 == 2);
            for (k = 0; k < PHASE_LEN; k++) send_op(random_op(t_mix'(phase % 3)));
            if (phase % 4 == 3) hold_until_drained();
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS indexed_deque_store");
        end else begin
            $display("FAIL indexed_deque_store");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/ids_pkg.sv
hdl/indexed_deque_store.sv
tb/sv/indexed_deque_store_checker.sv
tb/sv/indexed_deque_store_tb.sv
